// ----- rtl/sids_pkg.sv -----
package sids_pkg;

  localparam logic [2:0] ACT_INS_A = 3'd0;
  localparam logic [2:0] ACT_INS_B = 3'd1;
  localparam logic [2:0] ACT_REM_A = 3'd2;
  localparam logic [2:0] ACT_REM_B = 3'd3;
  localparam logic [2:0] ACT_ISECT = 3'd4;
  localparam logic [2:0] ACT_CLEAR = 3'd5;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_REMOVED   = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_COMMON    = 3'd5;
  localparam logic [2:0] ST_EMPTY     = 3'd6;
  localparam logic [2:0] ST_CLEARED   = 3'd7;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] item_id;
  } sids_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] common_id;
    logic        last;
  } sids_out_t;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_SCAN     = 7'b0000010,
    S_SHIFT_DN = 7'b0000100,
    S_PUT      = 7'b0001000,
    S_SHIFT_UP = 7'b0010000,
    S_MERGE    = 7'b0100000,
    S_EMIT     = 7'b1000000
  } sids_state_e;

endpackage

// ----- rtl/sids_ram.sv -----
module sids_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

// ----- rtl/sorted_id_set_intersection.sv -----
// insert and remove walk the selected set memory and intersect walks both, all with
// registered reads; a new request is taken only in idle, after the previous one is done;
// a walk takes one stored entry per cycle unless held by a busy output; intersect delivers
// at most one common id per cycle while the output is taken
// reset clears both counts and the control state; set memories keep their contents
// and entries at or above a count are never read
module sorted_id_set_intersection #(
  parameter int SET_DEPTH = 64,
  parameter int ID_BITS   = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sids_pkg::sids_in_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sids_pkg::sids_out_t out_data_o
);
  import sids_pkg::*;

  localparam int IDW = (ID_BITS < 16) ? ID_BITS : 16;
  localparam int AW  = $clog2(SET_DEPTH);
  localparam int CW  = $clog2(SET_DEPTH + 1);

  sids_state_e state_q, state_d;
  logic [2:0]     op_q, op_d;
  logic           sel_b_q, sel_b_d;
  logic [IDW-1:0] id_q, id_d;
  logic [CW-1:0]  idx_q, idx_d, pos_q, pos_d, i_q, i_d, j_q, j_d;
  logic [CW-1:0]  cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic           pend_v_q, pend_v_d;
  logic [IDW-1:0] pend_id_q, pend_id_d;
  logic [2:0]     res_st_q, res_st_d;
  logic [IDW-1:0] res_id_q, res_id_d;
  logic           out_valid_q, out_valid_d;
  sids_out_t      out_q, out_d;

  logic           we, we_a, we_b;
  logic [AW-1:0]  wr_addr, addr_a, addr_b;
  logic [IDW-1:0] wr_data, rd_a, rd_b, rd_sel;
  logic [CW-1:0]  cnt_sel, idx_inc, idx_dec, i_inc, j_inc;
  logic           out_free, is_ins;

  assign cnt_sel  = sel_b_q ? cnt_b_q : cnt_a_q;
  assign rd_sel   = sel_b_q ? rd_b : rd_a;
  assign idx_inc  = idx_q + 1'b1;
  assign idx_dec  = idx_q - 1'b1;
  assign i_inc    = i_q + 1'b1;
  assign j_inc    = j_q + 1'b1;
  assign out_free = !out_valid_q || out_ready_i;
  assign is_ins   = (op_q == ACT_INS_A) || (op_q == ACT_INS_B);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    sel_b_d     = sel_b_q;
    id_d        = id_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    i_d         = i_q;
    j_d         = j_q;
    cnt_a_d     = cnt_a_q;
    cnt_b_d     = cnt_b_q;
    pend_v_d    = pend_v_q;
    pend_id_d   = pend_id_q;
    res_st_d    = res_st_q;
    res_id_d    = res_id_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    we          = 1'b0;
    wr_addr     = idx_q[AW-1:0];
    wr_data     = rd_sel;
    case (state_q)
      S_IDLE: begin
        idx_d = '0;
        i_d   = '0;
        j_d   = '0;
        if (in_valid_i) begin
          op_d     = in_data_i.action;
          sel_b_d  = in_data_i.action[0];
          id_d     = in_data_i.item_id[IDW-1:0];
          res_id_d = '0;
          case (in_data_i.action)
            ACT_INS_A, ACT_INS_B, ACT_REM_A, ACT_REM_B: begin
              state_d = S_SCAN;
            end
            ACT_ISECT: begin
              pend_v_d = 1'b0;
              if (cnt_a_q == '0 || cnt_b_q == '0) begin
                res_st_d = ST_EMPTY;
                state_d  = S_EMIT;
              end else begin
                state_d = S_MERGE;
              end
            end
            ACT_CLEAR: begin
              cnt_a_d  = '0;
              cnt_b_d  = '0;
              res_st_d = ST_CLEARED;
              state_d  = S_EMIT;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (idx_q == cnt_sel) begin
          if (!is_ins) begin
            res_st_d = ST_NOT_FOUND;
            state_d  = S_EMIT;
          end else if (cnt_sel == CW'(SET_DEPTH)) begin
            res_st_d = ST_FULL;
            state_d  = S_EMIT;
          end else begin
            pos_d   = idx_q;
            state_d = S_PUT;
          end
        end else if (is_ins) begin
          if (rd_sel < id_q) begin
            idx_d = idx_inc;
          end else if (rd_sel == id_q) begin
            res_st_d = ST_DUPLICATE;
            state_d  = S_EMIT;
          end else if (cnt_sel == CW'(SET_DEPTH)) begin
            res_st_d = ST_FULL;
            state_d  = S_EMIT;
          end else begin
            pos_d   = idx_q;
            idx_d   = cnt_sel - 1'b1;
            state_d = S_SHIFT_DN;
          end
        end else if (rd_sel == id_q) begin
          if (idx_inc == cnt_sel) begin
            if (sel_b_q) cnt_b_d = cnt_b_q - 1'b1;
            else cnt_a_d = cnt_a_q - 1'b1;
            res_st_d = ST_REMOVED;
            state_d  = S_EMIT;
          end else begin
            idx_d   = idx_inc;
            state_d = S_SHIFT_UP;
          end
        end else begin
          idx_d = idx_inc;
        end
      end
      S_SHIFT_DN: begin
        we      = 1'b1;
        wr_addr = idx_inc[AW-1:0];
        if (idx_q == pos_q) begin
          state_d = S_PUT;
        end else begin
          idx_d = idx_dec;
        end
      end
      S_PUT: begin
        we      = 1'b1;
        wr_addr = pos_q[AW-1:0];
        wr_data = id_q;
        if (sel_b_q) cnt_b_d = cnt_b_q + 1'b1;
        else cnt_a_d = cnt_a_q + 1'b1;
        res_st_d = ST_INSERTED;
        state_d  = S_EMIT;
      end
      S_SHIFT_UP: begin
        we      = 1'b1;
        wr_addr = idx_dec[AW-1:0];
        if (idx_inc == cnt_sel) begin
          if (sel_b_q) cnt_b_d = cnt_b_q - 1'b1;
          else cnt_a_d = cnt_a_q - 1'b1;
          res_st_d = ST_REMOVED;
          state_d  = S_EMIT;
        end else begin
          idx_d = idx_inc;
        end
      end
      S_MERGE: begin
        if (!(rd_a == rd_b && pend_v_q && !out_free)) begin
          if (rd_a == rd_b) begin
            if (pend_v_q) begin
              out_valid_d = 1'b1;
              out_d       = '{status: ST_COMMON, common_id: 16'(pend_id_q), last: 1'b0};
            end
            pend_v_d  = 1'b1;
            pend_id_d = rd_a;
            i_d       = i_inc;
            j_d       = j_inc;
          end else if (rd_a > rd_b) begin
            j_d = j_inc;
          end else begin
            i_d = i_inc;
          end
          if (i_d == cnt_a_q || j_d == cnt_b_q) begin
            res_st_d = pend_v_d ? ST_COMMON : ST_EMPTY;
            res_id_d = pend_v_d ? pend_id_d : '0;
            state_d  = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{status: res_st_q, common_id: 16'(res_id_q), last: 1'b1};
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign we_a   = we && !sel_b_q;
  assign we_b   = we && sel_b_q;
  assign addr_a = (state_q == S_MERGE) ? i_d[AW-1:0] : idx_d[AW-1:0];
  assign addr_b = (state_q == S_MERGE) ? j_d[AW-1:0] : idx_d[AW-1:0];

  sids_ram #(.DEPTH(SET_DEPTH), .WIDTH(IDW)) u_ram_a (
    .clk_i     (clk_i),
    .we_i      (we_a),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (addr_a),
    .rd_data_o (rd_a)
  );

  sids_ram #(.DEPTH(SET_DEPTH), .WIDTH(IDW)) u_ram_b (
    .clk_i     (clk_i),
    .we_i      (we_b),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (addr_b),
    .rd_data_o (rd_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_a_q     <= cnt_a_d;
      cnt_b_q     <= cnt_b_d;
      pend_v_q    <= pend_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    sel_b_q   <= sel_b_d;
    id_q      <= id_d;
    idx_q     <= idx_d;
    pos_q     <= pos_d;
    i_q       <= i_d;
    j_q       <= j_d;
    pend_id_q <= pend_id_d;
    res_st_q  <= res_st_d;
    res_id_q  <= res_id_d;
    out_q     <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_a_q <= CW'(SET_DEPTH)) && (cnt_b_q <= CW'(SET_DEPTH)))
    else $error("set count above depth");

  a_merge_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MERGE) |-> (i_q < cnt_a_q) && (j_q < cnt_b_q))
    else $error("merge index past set end");

  a_put_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUT) |-> (cnt_sel < CW'(SET_DEPTH)) && (pos_q <= cnt_sel))
    else $error("insert into full set");

  a_emit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) && out_free |=> out_valid_o && out_data_o.last)
    else $error("final transfer not marked last");

endmodule
